>>> hw/rtl/leb_pkg.sv
`timescale 1ns / 1ps

package leb_pkg;

  // Widest integer the decoder produces
  localparam int VALUE_WIDTH = 64;

  // Bit position of the tenth byte, which may carry only the top bit
  localparam logic [5:0] TOP_BIT_POS = 6'd63;
  // Highest bit position at which a continuation byte is still legal
  localparam logic [5:0] LAST_CONT_POS = 6'd56;
  // Payload bits per encoded byte
  localparam logic [5:0] GROUP_BITS = 6'd7;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_END   = 2'd1,
    ST_LONG  = 2'd2,
    ST_LARGE = 2'd3
  } status_t;

  // One accepted input transfer
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
    logic       mode;
    logic [6:0] width_bits;
  } item_t;

  // Decoder state carried between bytes
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] acc;
    logic [5:0]             bit_pos;
    logic [3:0]             byte_cnt;
    logic [6:0]             held_width;
    logic                   held_signed;
  } dec_state_t;

  // Result of one step
  typedef struct packed {
    logic                   valid;
    logic [VALUE_WIDTH-1:0] value;
    status_t                status;
    logic [3:0]             bytes_used;
  } result_t;

endpackage

>>> hw/rtl/leb128_checked_decoder.sv
`timescale 1ns / 1ps

// Channel  Direction  tdata                        tuser
// in_      slave      data_byte[7:0]               end_of_data, mode, width_bits[6:0]
// out_     master     value[63:0], bytes_used[3:0] status[1:0]
//
// One byte per cycle while the result side is not stalled; a result becomes valid
// once its terminal byte has passed the input register and then the result register.
// The step logic between those registers sets the rate.
// Reset clears the decoder to idle and empties both registers.
// A stalled result holds the result register; input keeps flowing into the
// input register until it is full too.
module leb128_checked_decoder import leb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic [8:0]  in_tuser,   // end_of_data[0], mode[1], width_bits[8:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // value[63:0], bytes_used[67:64], zero[71:68]
  output logic [1:0]  out_tuser   // status[1:0]
);

  logic       in_valid_r;
  item_t      in_item_r;
  dec_state_t state_r;
  dec_state_t state_nxt;
  result_t    step_res;
  result_t    out_r;
  logic       advance;

  // Step the decoder when a byte is held and the result register can take a result
  assign advance   = in_valid_r && (!out_r.valid || out_tready);
  assign in_tready = !in_valid_r || advance;

  leb_step u_step (
    .item (in_item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (step_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      in_item_r.data_byte   <= in_tdata;
      in_item_r.end_of_data <= in_tuser[0];
      in_item_r.mode        <= in_tuser[1];
      in_item_r.width_bits  <= in_tuser[8:2];
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (advance) begin
      out_r.valid <= step_res.valid;
    end else if (out_tready) begin
      out_r.valid <= 1'b0;
    end
    if (advance && step_res.valid) begin
      out_r.value      <= step_res.value;
      out_r.status     <= step_res.status;
      out_r.bytes_used <= step_res.bytes_used;
    end
  end

  assign out_tvalid = out_r.valid;
  assign out_tdata  = {4'd0, out_r.bytes_used, out_r.value};
  assign out_tuser  = out_r.status;

endmodule

>>> hw/rtl/leb_step.sv
`timescale 1ns / 1ps

// One decode step: current state and one byte in, next state and optional result out
module leb_step import leb_pkg::*; (
  input  item_t      item,
  input  dec_state_t cur,
  output dec_state_t nxt,
  output result_t    res
);

  logic                   first;
  logic [6:0]             in_w_clamped;
  logic [6:0]             eff_w;
  logic [6:0]             eff_w_m1;
  logic                   eff_s;
  logic [VALUE_WIDTH-1:0] acc;
  logic [5:0]             bp;
  logic [3:0]             n;
  logic [7:0]             b;
  logic                   too_long;
  logic                   top_bit;
  logic                   narrow;
  logic [VALUE_WIDTH-1:0] shifted;
  logic [VALUE_WIDTH-1:0] sign_fill;
  logic [VALUE_WIDTH-1:0] r;
  logic [VALUE_WIDTH-1:0] zone;
  logic [VALUE_WIDTH-1:0] ones_zone;
  logic                   large_u;
  logic                   large_s;

  // Latch width and mode on the first byte of a number
  always_comb begin
    first        = (cur.byte_cnt == 4'd0);
    in_w_clamped = (item.width_bits > 7'(VALUE_WIDTH)) ? 7'(VALUE_WIDTH) : item.width_bits;
    eff_w        = first ? in_w_clamped : cur.held_width;
    eff_s        = first ? item.mode : cur.held_signed;
    acc          = first ? '0 : cur.acc;
    bp           = first ? '0 : cur.bit_pos;
    eff_w_m1     = eff_w - 7'd1;
    n            = cur.byte_cnt + 4'd1;
    b            = item.data_byte;
  end

  // bit_pos is always 7 * byte_cnt, so the byte limit ceil(w/7) reduces to one compare
  assign too_long = ({1'b0, bp} >= eff_w);
  assign top_bit  = (bp == TOP_BIT_POS);
  assign narrow   = (eff_w < 7'(VALUE_WIDTH));

  // Assemble the value of a terminal byte
  always_comb begin
    shifted   = {{(VALUE_WIDTH-7){1'b0}}, b[6:0]} << bp;
    sign_fill = (eff_s && !top_bit && b[6]) ? ({VALUE_WIDTH{1'b1}} << (bp + GROUP_BITS)) : '0;
    r         = acc | shifted | sign_fill;
    zone      = r >> eff_w_m1;
    ones_zone = {VALUE_WIDTH{1'b1}} >> eff_w_m1;
    large_u   = (top_bit && (b[6:1] != 6'd0)) || (narrow && ((r >> eff_w) != '0));
    large_s   = (top_bit && (b != 8'h00) && (b != 8'h7F)) ||
                (narrow && (eff_w != 7'd0) && (zone != '0) && (zone != ones_zone));
  end

  // Step decision
  always_comb begin
    nxt            = '0;
    res.valid      = 1'b1;
    res.value      = '0;
    res.status     = ST_OK;
    res.bytes_used = n;
    if (item.end_of_data) begin
      res.status     = ST_END;
      res.bytes_used = cur.byte_cnt;
    end else if (too_long) begin
      res.status = ST_LONG;
    end else if (b[7]) begin
      // continuation byte
      if (bp > LAST_CONT_POS) begin
        res.status = ST_LONG;
      end else begin
        res.valid       = 1'b0;
        nxt.acc         = acc | shifted;
        nxt.bit_pos     = bp + GROUP_BITS;
        nxt.byte_cnt    = n;
        nxt.held_width  = eff_w;
        nxt.held_signed = eff_s;
      end
    end else if (eff_s ? large_s : large_u) begin
      res.status = ST_LARGE;
    end else begin
      res.value = r;
    end
  end

endmodule

>>> hw/rtl/leb_chk.sv
`timescale 1ns / 1ps

// Port-level checks on the decoder's result stream
module leb_chk import leb_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Errors carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata[63:0] == 64'd0))
    else $error("error result with nonzero value");

  // Byte count stays within ten, and only an end transfer may report zero bytes
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[67:64] <= 4'd10) &&
                   ((out_tdata[67:64] != 4'd0) || (out_tuser == ST_END)))
    else $error("bad bytes_used");

  // Nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind leb128_checked_decoder leb_chk u_leb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> verif/leb128_checked_decoder_tb.sv
`timescale 1ns / 1ps

module leb128_checked_decoder_tb;
  import leb_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 8;

  // Legal signed tenth byte when the value is negative
  localparam logic [7:0] NEG_TOP_BYTE = 8'h7F;

  // One decoded number as the output channel should carry it
  typedef struct {
    logic [63:0] value;
    status_t     status;
    logic [3:0]  used;
  } decoded_t;

  // Decoder model plus the queue of decoded numbers still to arrive
  class leb_scoreboard;
    logic [63:0] acc;
    logic [5:0]  bit_pos;
    logic [3:0]  byte_cnt;
    logic [6:0]  held_width;
    logic        held_signed;
    decoded_t    decoded_q[$];
    int          errors;

    function new();
      errors = 0;
      go_idle();
    endfunction

    function void go_idle();
      acc         = '0;
      bit_pos     = '0;
      byte_cnt    = '0;
      held_width  = '0;
      held_signed = 1'b0;
    endfunction

    function void report(string msg);
      errors++;
      $display("[tb] mismatch: %s", msg);
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    // Queue a finished number and drop back to idle
    function void finish_number(logic [63:0] v, status_t st, int unsigned used);
      decoded_t d;
      d.value  = v;
      d.status = st;
      d.used   = 4'(used);
      decoded_q.push_back(d);
      go_idle();
    endfunction

    // Advance the decoder model by one accepted input transfer
    function void note_input(item_t it);
      int unsigned n;
      int unsigned maxb;
      int unsigned w;
      logic [63:0] r;
      logic [63:0] zone;
      if (it.end_of_data) begin
        finish_number('0, ST_END, byte_cnt);
        return;
      end
      // First byte latches width (clamped) and signedness
      if (byte_cnt == 0) begin
        w = it.width_bits;
        if (w > VALUE_WIDTH) w = VALUE_WIDTH;
        held_width  = 7'(w);
        held_signed = it.mode;
        acc         = '0;
        bit_pos     = '0;
      end
      n    = byte_cnt + 1;
      maxb = (held_width + 6) / 7;
      if (n > maxb) begin
        finish_number('0, ST_LONG, n);
        return;
      end
      // Continuation byte
      if (it.data_byte[7]) begin
        if (bit_pos > LAST_CONT_POS) begin
          finish_number('0, ST_LONG, n);
          return;
        end
        acc      = acc | (64'(it.data_byte[6:0]) << bit_pos);
        bit_pos  = bit_pos + GROUP_BITS;
        byte_cnt = 4'(n);
        return;
      end
      // Terminal byte
      r = acc;
      if (!held_signed) begin
        if (bit_pos == TOP_BIT_POS) begin
          if (it.data_byte[6:1] != '0) begin
            finish_number('0, ST_LARGE, n);
            return;
          end
          r[63] = r[63] | it.data_byte[0];
        end else begin
          r = r | (64'(it.data_byte[6:0]) << bit_pos);
        end
        if (held_width < 64 && (r >> held_width) != '0) begin
          finish_number('0, ST_LARGE, n);
          return;
        end
      end else begin
        if (bit_pos == TOP_BIT_POS) begin
          if (it.data_byte != 8'h00 && it.data_byte != NEG_TOP_BYTE) begin
            finish_number('0, ST_LARGE, n);
            return;
          end
          r[63] = r[63] | it.data_byte[0];
        end else begin
          r = r | (64'(it.data_byte[6:0]) << bit_pos);
          if (it.data_byte[6]) r = r | ({64{1'b1}} << (bit_pos + 7));
        end
        // Bits from width-1 up must all match the sign
        if (held_width >= 1 && held_width < 64) begin
          zone = r >> (held_width - 1);
          if (zone != '0 && zone != ({64{1'b1}} >> (held_width - 1))) begin
            finish_number('0, ST_LARGE, n);
            return;
          end
        end
      end
      finish_number(r, ST_OK, n);
    endfunction

    // Compare one output transfer with the oldest decoded number
    function void check_result(logic [63:0] v, status_t st, logic [3:0] used);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected result value=%h status=%0d used=%0d", v, st, used));
        return;
      end
      want = decoded_q.pop_front();
      if (v !== want.value)
        report($sformatf("value %h, want %h", v, want.value));
      if (st !== want.status)
        report($sformatf("status %0d, want %0d", st, want.status));
      if (used !== want.used)
        report($sformatf("bytes_used %0d, want %0d", used, want.used));
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // data_byte[7:0]
  logic [8:0]  in_tuser   = '0;   // end_of_data[0], mode[1], width_bits[8:2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;         // value[63:0], bytes_used[67:64], zero[71:68]
  logic [1:0]  out_tuser;         // status[1:0]

  leb_scoreboard sb;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  logic        rx_hold      = 1'b0;
  int          items_sent   = 0;
  int          cycles       = 0;

  leb128_checked_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[leb128_checked_decoder] ERROR");
      $finish;
    end
  end

  // Output side: check each transfer, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[63:0], status_t'(out_tuser), out_tdata[67:64]);
    out_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // Offer one item, idling first at random, and wait for its transfer
  task automatic send_item(item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.data_byte;
    in_tuser  <= {it.width_bits, it.mode, it.end_of_data};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] data, logic eod, logic mode, logic [6:0] width);
    item_t it;
    it.data_byte   = data;
    it.end_of_data = eod;
    it.mode        = mode;
    it.width_bits  = width;
    send_item(it);
  endtask

  task automatic run_directed();
    int i;
    send_byte(8'h55, 1'b1, 1'b0, 7'd1);     // end while idle
    send_byte(8'h01, 1'b0, 1'b0, 7'd1);     // unsigned max of one bit
    send_byte(8'h02, 1'b0, 1'b0, 7'd1);     // one bit overflow
    send_byte(8'h7F, 1'b0, 1'b1, 7'd1);     // signed -1 in one bit
    send_byte(8'h00, 1'b0, 1'b0, 7'd0);     // zero width: too long at once
    send_byte(8'h40, 1'b0, 1'b1, 7'd127);   // width clamped to 64
    send_byte(8'h80, 1'b0, 1'b0, 7'd7);     // second byte past the limit
    send_byte(8'h00, 1'b0, 1'b0, 7'd7);
    send_byte(8'h80, 1'b0, 1'b1, 7'd8);     // -128 in 8 bits; later fields ignored
    send_byte(8'h7F, 1'b0, 1'b0, 7'd0);
    send_byte(8'hFF, 1'b0, 1'b0, 7'd64);    // end within a number
    send_byte(8'hAA, 1'b1, 1'b1, 7'd3);
    for (i = 0; i < 9; i++)                  // all ones over ten bytes
      send_byte(8'hFF, 1'b0, 1'b0, 7'd64);
    send_byte(8'h01, 1'b0, 1'b0, 7'd64);
  endtask

  // One random number: mostly well formed, sometimes overlong,
  // out of range, corrupted, cut short by an end marker or pure noise
  task automatic send_random_number();
    item_t       it;
    logic [6:0]  wf;
    logic        sgn;
    logic [63:0] v;
    logic [7:0]  b;
    int unsigned w;
    int unsigned maxb;
    int unsigned len;
    int unsigned k;
    int unsigned cut;
    int unsigned flip_at;
    int unsigned pick;
    int          i;
    pick = $urandom_range(99);
    // Pure noise
    if (pick < 5) begin
      it.data_byte   = 8'($urandom);
      it.end_of_data = ($urandom_range(3) == 0);
      it.mode        = 1'($urandom);
      it.width_bits  = 7'($urandom);
      send_item(it);
      return;
    end
    pick = $urandom_range(99);
    if (pick < 4) wf = 7'd0;
    else if (pick < 12) wf = 7'($urandom_range(65, 127));
    else if (pick < 35) begin
      case ($urandom_range(4))
        0:       wf = 7'd1;
        1:       wf = 7'd7;
        2:       wf = 7'd8;
        3:       wf = 7'd63;
        default: wf = 7'd64;
      endcase
    end else wf = 7'($urandom_range(1, 64));
    w    = (wf > 64) ? 64 : wf;
    sgn  = 1'($urandom);
    maxb = (w + 6) / 7;
    if (maxb == 0) len = 1;
    else begin
      len = $urandom_range(1, maxb);
      if ($urandom_range(99) < 8) len = maxb + 1;
    end
    // Value that fits the width and the byte count, unless left raw
    v = {$urandom, $urandom};
    if ($urandom_range(2) == 0) v = v >> $urandom_range(63);
    k = (w < 7 * len) ? w : 7 * len;
    if ($urandom_range(9) != 0 && k < 64) begin
      if (sgn && k > 0 && v[k-1]) v = v | ({64{1'b1}} << k);
      else v = v & ~({64{1'b1}} << k);
    end
    cut = len;
    if ($urandom_range(99) < 7) cut = $urandom_range(0, len - 1);
    flip_at = len;
    if ($urandom_range(99) < 8) flip_at = $urandom_range(0, len - 1);
    for (i = 0; i < cut; i++) begin
      b[6:0] = sgn ? 7'($signed(v) >>> (7 * i)) : 7'(v >> (7 * i));
      b[7]   = (i < len - 1);
      if (i == flip_at) b = b ^ (8'd1 << $urandom_range(7));
      if (i == 0) send_byte(b, 1'b0, sgn, wf);
      else send_byte(b, 1'b0, 1'($urandom), 7'($urandom));
    end
    if (cut < len) send_byte(8'($urandom), 1'b1, 1'($urandom), 7'($urandom));
  endtask

  initial begin
    int ph;
    int target;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    // Random phases with different idling on each side
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
          // Long output hold-off while input keeps coming
          fork
            begin
              rx_hold <= 1'b1;
              repeat (HOLDOFF_CYCLES) @(posedge clk);
              rx_hold <= 1'b0;
            end
          join_none
        end
        1: begin
          tx_idle_pct = 60;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 60;
        end
        default: begin
          tx_idle_pct = 22;
          rx_stall_pct <= 22;
        end
      endcase
      target = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < target) send_random_number();
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("[leb128_checked_decoder] OK");
    else
      $display("[leb128_checked_decoder] ERROR");
    $finish;
  end

endmodule

>>> leb128_checked_decoder.f
hw/rtl/leb_pkg.sv
hw/rtl/leb_step.sv
hw/rtl/leb128_checked_decoder.sv
hw/rtl/leb_chk.sv
verif/leb128_checked_decoder_tb.sv
